@@ rtl/core/rse_pkg.sv @@
// ----------------------------------------------------------------------------
// rse_pkg: shared types and constants of the RPN stack evaluator
// Token kind codes, status codes, the controller state type and the
// per-cell shift control.
// ----------------------------------------------------------------------------
package rse_pkg;

   localparam int DATA_W          = 32;
   localparam int TYPE_W          = 3;
   localparam int STACK_DEPTH_DEF = 64;

   // token kinds
   localparam logic [TYPE_W-1:0] KIND_NUM = 3'd0;
   localparam logic [TYPE_W-1:0] KIND_ADD = 3'd1;
   localparam logic [TYPE_W-1:0] KIND_SUB = 3'd2;
   localparam logic [TYPE_W-1:0] KIND_MUL = 3'd3;
   localparam logic [TYPE_W-1:0] KIND_DIV = 3'd4;

   // sticky expression status
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_UNDER = 2'd1,
      ST_OVER  = 2'd2,
      ST_DIV0  = 2'd3
   } status_type;

   // controller states
   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_DIV,
      S_FIN
   } state_type;

   // shift control for one stack cell
   typedef struct packed {
      logic load;        // cell takes a new value this cycle
      logic from_below;  // new value comes from the deeper neighbor
   } cell_ctl_type;

endpackage

@@ rtl/core/rse_cell.sv @@
// ----------------------------------------------------------------------------
// rse_cell: one stack entry
// Holds a value, or takes it from the shallower neighbor (push) or the
// deeper neighbor (pop) as its control says.
// ----------------------------------------------------------------------------
module rse_cell (
   input  logic                          clock,
   input  rse_pkg::cell_ctl_type         ctl,
   input  logic [rse_pkg::DATA_W-1:0]    up_data,
   input  logic [rse_pkg::DATA_W-1:0]    down_data,
   output logic [rse_pkg::DATA_W-1:0]    q
);
   import rse_pkg::*;

   logic [DATA_W-1:0] val_ff;
   logic [DATA_W-1:0] val_in;

   // neighbor select
   always_comb begin
      val_in = val_ff;
      if (ctl.load) begin
         val_in = ctl.from_below ? down_data : up_data;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

   assign q = val_ff;

endmodule

@@ rtl/core/rse_divider.sv @@
// ----------------------------------------------------------------------------
// rse_divider: iterative signed divider
// Restoring division on magnitudes, one quotient bit per cycle, truncated
// toward zero. The divisor is never zero when started.
// ----------------------------------------------------------------------------
module rse_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [rse_pkg::DATA_W-1:0]    dividend,
   input  logic [rse_pkg::DATA_W-1:0]    divisor,
   output logic                          done,
   output logic [rse_pkg::DATA_W-1:0]    quotient
);
   import rse_pkg::*;

   localparam int CNT_W = $clog2(DATA_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              neg_ff, neg_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] dsr_ff, dsr_in;
   logic [DATA_W:0]   rem_sh;
   logic [DATA_W:0]   diff;

   // one restoring step per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      rem_sh  = {rem_ff, quo_ff[DATA_W-1]};
      diff    = rem_sh - {1'b0, dsr_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DATA_W - 1);
         neg_in  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
         quo_in  = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
         dsr_in  = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (!diff[DATA_W]) begin
            rem_in = diff[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   // most negative by minus one wraps back to most negative here
   assign done     = done_ff;
   assign quotient = neg_ff ? (~quo_ff + 1'b1) : quo_ff;

endmodule

@@ rtl/core/rpn_stack_evaluator_top.sv @@
// ----------------------------------------------------------------------------
// rpn_stack_evaluator_top: reverse Polish expression evaluator
// A row of stack cells shifts down on a push and up on an operator; the top
// two cells feed the arithmetic. The final token of an expression returns
// the top of stack and a sticky status, then clears the stack.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  req_type, req_operand,
//                                            req_last_token
//   rsp      out        rsp_valid/rsp_ready  rsp_value, rsp_status
//
// A token is accepted in S_IDLE, then executed in S_EXEC; a divide waits in
// S_DIV for the bit-serial divider. A final token then passes through S_FIN to load
// the output register. One token is in flight at a time. Output stalls hold
// only the final token of the next expression; other tokens are still taken.
// Reset clears the controller, stack count, status and output valid.
// ----------------------------------------------------------------------------
module rpn_stack_evaluator_top #(
   parameter int STACK_DEPTH = rse_pkg::STACK_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [rse_pkg::TYPE_W-1:0]    req_type,
   input  logic [rse_pkg::DATA_W-1:0]    req_operand,
   input  logic                          req_last_token,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rse_pkg::DATA_W-1:0]    rsp_value,
   output logic [1:0]                    rsp_status
);
   import rse_pkg::*;

   localparam int CNT_W = $clog2(STACK_DEPTH + 1);

   state_type          state_ff, state_in;
   logic [TYPE_W-1:0]  tok_type_ff;
   logic [DATA_W-1:0]  tok_operand_ff;
   logic               tok_last_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   status_type         error_ff, error_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]  rsp_value_ff, rsp_value_in;
   status_type         rsp_status_ff, rsp_status_in;

   logic               accept;
   logic               push_en;
   logic               pop_en;
   logic [DATA_W-1:0]  new_top;
   logic [DATA_W-1:0]  alu_res;
   logic               div_start;
   logic               div_done;
   logic [DATA_W-1:0]  div_quot;
   logic [DATA_W-1:0]  cell_q [STACK_DEPTH];
   cell_ctl_type       cell_ctl [STACK_DEPTH];

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   // token capture
   always_ff @(posedge clock) begin
      if (accept) begin
         tok_type_ff    <= req_type;
         tok_operand_ff <= req_operand;
         tok_last_ff    <= req_last_token;
      end
   end

   // add, subtract, multiply on the top two cells (left is the deeper one)
   always_comb begin
      case (tok_type_ff)
         KIND_ADD: alu_res = cell_q[1] + cell_q[0];
         KIND_SUB: alu_res = cell_q[1] - cell_q[0];
         default:  alu_res = cell_q[1] * cell_q[0];
      endcase
   end

   // controller: next state, stack moves, status, output register
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      error_in      = error_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      push_en       = 1'b0;
      pop_en        = 1'b0;
      new_top       = tok_operand_ff;
      div_start     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = tok_last_ff ? S_FIN : S_IDLE;
            case (tok_type_ff) inside
               KIND_NUM: begin
                  if (count_ff >= CNT_W'(STACK_DEPTH)) begin
                     if (error_ff == ST_OK) error_in = ST_OVER;
                  end else begin
                     push_en  = 1'b1;
                     count_in = count_ff + 1'b1;
                  end
               end
               KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV: begin
                  if (count_ff < CNT_W'(2)) begin
                     if (error_ff == ST_OK) error_in = ST_UNDER;
                  end else if (tok_type_ff == KIND_DIV) begin
                     if (cell_q[0] == '0) begin
                        if (error_ff == ST_OK) error_in = ST_DIV0;
                        new_top  = '0;
                        pop_en   = 1'b1;
                        count_in = count_ff - 1'b1;
                     end else begin
                        div_start = 1'b1;
                        state_in  = S_DIV;
                     end
                  end else begin
                     new_top  = alu_res;
                     pop_en   = 1'b1;
                     count_in = count_ff - 1'b1;
                  end
               end
               default: ;
            endcase
         end
         S_DIV: begin
            if (div_done) begin
               new_top  = div_quot;
               pop_en   = 1'b1;
               count_in = count_ff - 1'b1;
               state_in = tok_last_ff ? S_FIN : S_IDLE;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               if (count_ff == '0) begin
                  rsp_value_in  = '0;
                  rsp_status_in = (error_ff == ST_OK) ? ST_UNDER : error_ff;
               end else begin
                  rsp_value_in  = cell_q[0];
                  rsp_status_in = error_ff;
               end
               count_in = '0;
               error_in = ST_OK;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         error_ff     <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         error_ff     <= error_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

   // stack cell row: cell 0 is the top of stack
   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      logic [DATA_W-1:0] up_d;
      logic [DATA_W-1:0] down_d;

      if (i == 0) begin : g_head
         assign up_d                = new_top;
         assign cell_ctl[i].load       = push_en || pop_en;
         assign cell_ctl[i].from_below = 1'b0;
      end else begin : g_body
         assign up_d                = cell_q[i-1];
         assign cell_ctl[i].load       = push_en || pop_en;
         assign cell_ctl[i].from_below = pop_en;
      end

      if (i == STACK_DEPTH - 1) begin : g_tail
         assign down_d = cell_q[i];
      end else begin : g_mid
         assign down_d = cell_q[i+1];
      end

      rse_cell u_cell (
         .clock     (clock),
         .ctl       (cell_ctl[i]),
         .up_data   (up_d),
         .down_data (down_d),
         .q         (cell_q[i])
      );
   end

   // bit-serial divider for divide tokens
   rse_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (cell_q[1]),
      .divisor  (cell_q[0]),
      .done     (div_done),
      .quotient (div_quot)
   );

endmodule

@@ rtl/core/rse_checker.sv @@
// ----------------------------------------------------------------------------
// rse_checker: port-level checks of the RPN stack evaluator
// Watches the top level's handshakes over time; bound to the top level.
// ----------------------------------------------------------------------------
module rse_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic                          req_last_token,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [rse_pkg::DATA_W-1:0]    rsp_value,
   input  logic [1:0]                    rsp_status
);
   import rse_pkg::*;

   // no result beat right out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // a stalled result beat holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_status))
      else $error("result beat changed while stalled");

   // one token in flight: ready drops after every accepted beat
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("token accepted while previous token busy");

   // a token that is not last never raises a result
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_last_token && !rsp_valid |=> !rsp_valid)
      else $error("result beat without final token");

endmodule

bind rpn_stack_evaluator_top rse_checker u_rse_checker (.*);
